// File: design/common_substring_run_finder_macros.svh
// ----------------------------------------------------------------------------
// Common substring run finder assertion macros
// Short forms for clocked, reset-gated implication checks.
// ----------------------------------------------------------------------------
`ifndef COMMON_SUBSTRING_RUN_FINDER_MACROS_SVH
`define COMMON_SUBSTRING_RUN_FINDER_MACROS_SVH

// same-cycle implication
`define CSRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("common_substring_run_finder: check failed");

// next-cycle implication
`define CSRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("common_substring_run_finder: check failed");

`endif

// File: design/csrf_pkg.sv
// ----------------------------------------------------------------------------
// Common substring run finder package
// Sizes, command codes, controller states and the result record.
// ----------------------------------------------------------------------------
package csrf_pkg;

   localparam int B_LEN     = 64;
   localparam int B_AW      = 6;
   localparam int B_CW      = 7;
   localparam int CHAR_W    = 8;
   localparam int LEN_W     = 7;
   localparam int A_W       = 21;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [A_W-1:0]   A_LEN_MAX      = 21'd1048576;
   localparam logic [B_CW-1:0]  B_FULL         = 7'd64;
   localparam logic [LEN_W-1:0] MIN_SIZE_RESET = 7'd50;
   localparam logic [LEN_W-1:0] MIN_SIZE_FLOOR = 7'd2;
   localparam logic             CSR_MIN_SIZE   = 1'b0;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_COMPARE = 2'd1,
      CMD_FINISH  = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [A_W-1:0]   a_end;
      logic [B_CW-1:0]  b_end;
      logic [LEN_W-1:0] run_length;
   } result_type;

endpackage

// File: design/csrf_ram.sv
// ----------------------------------------------------------------------------
// Common substring run finder RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module csrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/common_substring_run_finder.sv
// ----------------------------------------------------------------------------
// Common substring run finder
// Stores text B, sweeps a row of diagonal run lengths for each A character
// and reports every run that closes at or above the minimum length.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_cmd, req_char_value
//   rsp      out        rsp_valid/rsp_stall   rsp_a_end, rsp_b_end,
//                                             rsp_run_length, rsp_last
//   csr      in/out     psel/penable/pready   paddr, pwdata, prdata
//
// Load, clear, and compare or finish on an empty text B complete in idle.
// Otherwise compare steps through sweep, tail and flush and finish through
// sweep and flush, one row cell per cycle unless the output stalls, through
// the single read port of the run-row RAM. Reset is synchronous; the run row
// reads as zero after reset through per-entry valid bits, so no clearing pass
// is needed. A stalled result output holds the sweep in place until the item is taken.
// ----------------------------------------------------------------------------
`include "common_substring_run_finder_macros.svh"

module common_substring_run_finder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [csrf_pkg::CHAR_W-1:0]      req_char_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [csrf_pkg::A_W-1:0]         rsp_a_end,
   output logic [csrf_pkg::B_CW-1:0]        rsp_b_end,
   output logic [csrf_pkg::LEN_W-1:0]       rsp_run_length,
   output logic                             rsp_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [csrf_pkg::CSR_AW-1:0]      paddr,
   input  logic [csrf_pkg::CSR_DW-1:0]      pwdata,
   output logic [csrf_pkg::CSR_DW-1:0]      prdata,
   output logic                             pready
);

   csrf_pkg::state_type             state_ff, state_in;
   csrf_pkg::cmd_type               op_ff, op_in;
   logic [csrf_pkg::B_AW-1:0]       p_ff, p_in;
   logic [csrf_pkg::B_CW-1:0]       b_count_ff, b_count_in;
   logic [csrf_pkg::A_W-1:0]        apos_ff, apos_in;
   logic [csrf_pkg::A_W-1:0]        pos_ff, pos_in;
   logic [csrf_pkg::CHAR_W-1:0]     ch_ff, ch_in;
   logic [csrf_pkg::LEN_W-1:0]      min_size_ff, min_size_in;
   logic [csrf_pkg::B_LEN-1:0]      row_vld_ff, row_vld_in;
   logic                            rv_q_ff, rv_q_in;
   logic [csrf_pkg::LEN_W-1:0]      prev_ff, prev_in;
   logic                            pend_vld_ff, pend_vld_in;
   csrf_pkg::result_type            pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_last_ff, rsp_last_in;
   csrf_pkg::result_type            rsp_ff, rsp_in;

   logic                            req_accept;
   csrf_pkg::cmd_type               cmd;
   logic                            out_free;
   logic                            step;
   logic                            last_idx;
   logic                            match;
   logic                            is_cmp;
   logic                            b_full;
   logic [csrf_pkg::LEN_W-1:0]      minv;
   logic [csrf_pkg::LEN_W-1:0]      row_val;
   logic                            gen_vld;
   csrf_pkg::result_type            gen;
   logic                            csr_wr;

   logic                            rd_en;
   logic [csrf_pkg::B_AW-1:0]       rd_addr;
   logic [csrf_pkg::CHAR_W-1:0]     b_rd_data;
   logic [csrf_pkg::LEN_W-1:0]      row_rd_data;
   logic                            b_wr_en;
   logic                            row_wr_en;
   logic [csrf_pkg::LEN_W-1:0]      row_wr_data;

   csrf_ram #(.WIDTH(csrf_pkg::CHAR_W), .DEPTH(csrf_pkg::B_LEN)) u_b_text (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_count_ff[csrf_pkg::B_AW-1:0]),
      .wr_data (req_char_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (b_rd_data)
   );

   csrf_ram #(.WIDTH(csrf_pkg::LEN_W), .DEPTH(csrf_pkg::B_LEN)) u_run_row (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (p_ff),
      .wr_data (row_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (row_rd_data)
   );

   assign cmd        = csrf_pkg::cmd_type'(req_cmd);
   assign req_stall  = (state_ff != csrf_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = (state_ff == csrf_pkg::ST_SWEEP) && out_free;
   assign last_idx   = ({1'b0, p_ff} == (b_count_ff - 7'd1));
   assign match      = (b_rd_data == ch_ff);
   assign is_cmp     = (op_ff == csrf_pkg::CMD_COMPARE);
   assign b_full     = (b_count_ff == csrf_pkg::B_FULL);
   assign minv       = (min_size_ff < csrf_pkg::MIN_SIZE_FLOOR) ?
                       csrf_pkg::MIN_SIZE_FLOOR : min_size_ff;
   assign row_val    = rv_q_ff ? row_rd_data : '0;

   assign rd_en       = (state_ff == csrf_pkg::ST_IDLE) || (step && !last_idx);
   assign rd_addr     = (state_ff == csrf_pkg::ST_IDLE) ? '0 : p_ff + 6'd1;
   assign b_wr_en     = req_accept && (cmd == csrf_pkg::CMD_LOAD) && !b_full;
   assign row_wr_en   = step && is_cmp;
   assign row_wr_data = match ? prev_ff + 7'd1 : '0;

   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign prdata  = (paddr[2] == csrf_pkg::CSR_MIN_SIZE) ?
                    {{(csrf_pkg::CSR_DW-csrf_pkg::LEN_W){1'b0}}, min_size_ff} : '0;

   always_comb begin
      gen_vld = 1'b0;
      gen     = '{a_end: pos_ff, b_end: {1'b0, p_ff}, run_length: prev_ff};
      if (step) begin
         if (is_cmp) begin
            gen_vld = !match && (p_ff != '0) && (prev_ff >= minv);
         end else begin
            gen_vld = (row_val >= minv);
            gen     = '{a_end: pos_ff, b_end: {1'b0, p_ff} + 7'd1, run_length: row_val};
         end
      end else if ((state_ff == csrf_pkg::ST_TAIL) && out_free) begin
         gen_vld = (prev_ff >= minv);
         gen     = '{a_end: pos_ff, b_end: b_count_ff, run_length: prev_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      p_in         = p_ff;
      b_count_in   = b_count_ff;
      apos_in      = apos_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      min_size_in  = min_size_ff;
      row_vld_in   = row_vld_ff;
      rv_q_in      = rv_q_ff;
      prev_in      = prev_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_in       = rsp_ff;

      if (csr_wr && (paddr[2] == csrf_pkg::CSR_MIN_SIZE)) begin
         min_size_in = pwdata[csrf_pkg::LEN_W-1:0];
      end

      if (rd_en) begin
         rv_q_in = row_vld_ff[rd_addr];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (gen_vld) begin
         pend_vld_in = 1'b1;
         pend_in     = gen;
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_in       = pend_ff;
         end
      end

      case (state_ff)
         csrf_pkg::ST_IDLE: begin
            prev_in = '0;
            p_in    = '0;
            if (req_accept) begin
               op_in  = cmd;
               ch_in  = req_char_value;
               pos_in = apos_ff;
               case (cmd)
                  csrf_pkg::CMD_LOAD: begin
                     if (!b_full) begin
                        row_vld_in[b_count_ff[csrf_pkg::B_AW-1:0]] = 1'b0;
                        b_count_in = b_count_ff + 7'd1;
                     end
                  end
                  csrf_pkg::CMD_COMPARE: begin
                     if (apos_ff < csrf_pkg::A_LEN_MAX) begin
                        apos_in = apos_ff + 21'd1;
                     end
                     if (b_count_ff != '0) begin
                        state_in = csrf_pkg::ST_SWEEP;
                     end
                  end
                  csrf_pkg::CMD_FINISH: begin
                     apos_in = '0;
                     if (b_count_ff != '0) begin
                        state_in = csrf_pkg::ST_SWEEP;
                     end else begin
                        row_vld_in = '0;
                     end
                  end
                  default: begin
                     b_count_in = '0;
                     apos_in    = '0;
                     row_vld_in = '0;
                  end
               endcase
            end
         end
         csrf_pkg::ST_SWEEP: begin
            if (step) begin
               prev_in = row_val;
               if (is_cmp) begin
                  row_vld_in[p_ff] = 1'b1;
               end
               if (last_idx) begin
                  state_in = is_cmp ? csrf_pkg::ST_TAIL : csrf_pkg::ST_FLUSH;
               end else begin
                  p_in = p_ff + 6'd1;
               end
            end
         end
         csrf_pkg::ST_TAIL: begin
            if (out_free) begin
               state_in = csrf_pkg::ST_FLUSH;
            end
         end
         csrf_pkg::ST_FLUSH: begin
            if (out_free || !pend_vld_ff) begin
               state_in = csrf_pkg::ST_IDLE;
               if (!is_cmp) begin
                  row_vld_in = '0;
               end
               if (pend_vld_ff) begin
                  pend_vld_in  = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_in       = pend_ff;
               end
            end
         end
         default: begin
            state_in = csrf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csrf_pkg::ST_IDLE;
         b_count_ff   <= '0;
         apos_ff      <= '0;
         min_size_ff  <= csrf_pkg::MIN_SIZE_RESET;
         row_vld_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_count_ff   <= b_count_in;
         apos_ff      <= apos_in;
         min_size_ff  <= min_size_in;
         row_vld_ff   <= row_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      p_ff        <= p_in;
      pos_ff      <= pos_in;
      ch_ff       <= ch_in;
      rv_q_ff     <= rv_q_in;
      prev_ff     <= prev_in;
      pend_ff     <= pend_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_a_end      = rsp_ff.a_end;
   assign rsp_b_end      = rsp_ff.b_end;
   assign rsp_run_length = rsp_ff.run_length;
   assign rsp_last       = rsp_last_ff;

   `CSRF_ASSERT_NOW(a_idle_no_pending, clock, reset,
      state_ff == csrf_pkg::ST_IDLE, !pend_vld_ff)
   `CSRF_ASSERT_NOW(a_sweep_in_b, clock, reset,
      state_ff == csrf_pkg::ST_SWEEP, {1'b0, p_ff} < b_count_ff)
   `CSRF_ASSERT_NOW(a_b_count_bound, clock, reset,
      1'b1, b_count_ff <= csrf_pkg::B_FULL)
   `CSRF_ASSERT_NEXT(a_flush_sends_last, clock, reset,
      state_ff == csrf_pkg::ST_FLUSH && pend_vld_ff && out_free,
      rsp_valid_ff && rsp_last_ff)

endmodule
